@@ rtl/core/acec_pkg.sv @@
// Package for the alignment column error counter.
// Holds the word types, count indexes and character helpers; no dependencies.
package acec_pkg;

  // Width of each running count.
  localparam int COUNT_BITS = 32;
  localparam int NUM_COUNTS = 10;
  localparam int FIELD_BITS = 32;

  localparam logic [7:0] GAP_CHAR = 8'h2D;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Positions of the counts, in result order.
  typedef enum logic [3:0] {
    CNT_SUB       = 4'd0,
    CNT_INS       = 4'd1,
    CNT_DEL       = 4'd2,
    CNT_EDIT      = 4'd3,
    CNT_CORR_TRUE = 4'd4,
    CNT_CORR_FALSE = 4'd5,
    CNT_UNC_TRUE  = 4'd6,
    CNT_UNC_FALSE = 4'd7,
    CNT_CORR_TOT  = 4'd8,
    CNT_UNC_TOT   = 4'd9
  } count_idx_t;

  typedef struct packed {
    logic [7:0] ref_char;
    logic [7:0] read_char;
    logic       last_column;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] substitutions;
    logic [FIELD_BITS-1:0] insertions;
    logic [FIELD_BITS-1:0] deletions;
    logic [FIELD_BITS-1:0] edit_total;
    logic [FIELD_BITS-1:0] corrected_true;
    logic [FIELD_BITS-1:0] corrected_false;
    logic [FIELD_BITS-1:0] uncorrected_true;
    logic [FIELD_BITS-1:0] uncorrected_false;
    logic [FIELD_BITS-1:0] corrected_total;
    logic [FIELD_BITS-1:0] uncorrected_total;
  } out_word_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  // Plain ASCII upper-case folding.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return is_lower(c) ? (c - CASE_OFFSET) : c;
  endfunction

endpackage

@@ rtl/core/alignment_column_error_counter.sv @@
// Alignment column error counter: classifies one column per word and keeps
// ten saturating counts, emitting them on the last column. Uses acec_pkg.
//
// A word is registered at input and classified and counted from that
// register; a last column's result is loaded into the result register
// that drives out_valid. Throughput: one column per cycle; input stalls
// only when a last column waits on a full result register. rst_n
// (synchronous) clears all counts and both valid flags.
module alignment_column_error_counter
  import acec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam count_t COUNT_MAX = '1;

  in_word_t  s1_r;
  logic      s1_v_r;
  logic      s1_adv;
  count_t    cnt_r [NUM_COUNTS];
  count_t    cnt_nxt [NUM_COUNTS];
  logic [NUM_COUNTS-1:0] inc;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t out_word_nxt;
  logic      s1_last;
  logic      cnt_zero;

  // Stage 1 moves on unless a last column meets a result that is still held.
  assign s1_last  = s1_v_r && s1_r.last_column;
  assign s1_adv   = s1_v_r && !(s1_r.last_column && out_valid_r && !out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  // Column classification.
  always_comb begin
    logic rgap, qgap, same, corr, unc;
    rgap = (s1_r.ref_char == GAP_CHAR);
    qgap = (s1_r.read_char == GAP_CHAR);
    same = (fold_case(s1_r.ref_char) == fold_case(s1_r.read_char));
    corr = is_upper(s1_r.read_char) || qgap;
    unc  = is_lower(s1_r.read_char);
    inc = '0;
    inc[CNT_SUB]        = !rgap && !qgap && !same;
    inc[CNT_INS]        = rgap && !qgap;
    inc[CNT_DEL]        = qgap && !rgap;
    inc[CNT_EDIT]       = (s1_r.ref_char != s1_r.read_char);
    inc[CNT_CORR_TRUE]  = corr && same;
    inc[CNT_CORR_FALSE] = corr && !same;
    inc[CNT_UNC_TRUE]   = unc && same;
    inc[CNT_UNC_FALSE]  = unc && !same;
    inc[CNT_CORR_TOT]   = corr;
    inc[CNT_UNC_TOT]    = unc;
  end

  // Saturating increments.
  always_comb begin
    for (int k = 0; k < NUM_COUNTS; k++) begin
      if (inc[k] && (cnt_r[k] != COUNT_MAX)) begin
        cnt_nxt[k] = cnt_r[k] + count_t'(1);
      end else begin
        cnt_nxt[k] = cnt_r[k];
      end
    end
  end

  // Result word built from the updated counts, low field bits of each.
  always_comb begin
    out_word_nxt.substitutions     = FIELD_BITS'(cnt_nxt[CNT_SUB]);
    out_word_nxt.insertions        = FIELD_BITS'(cnt_nxt[CNT_INS]);
    out_word_nxt.deletions         = FIELD_BITS'(cnt_nxt[CNT_DEL]);
    out_word_nxt.edit_total        = FIELD_BITS'(cnt_nxt[CNT_EDIT]);
    out_word_nxt.corrected_true    = FIELD_BITS'(cnt_nxt[CNT_CORR_TRUE]);
    out_word_nxt.corrected_false   = FIELD_BITS'(cnt_nxt[CNT_CORR_FALSE]);
    out_word_nxt.uncorrected_true  = FIELD_BITS'(cnt_nxt[CNT_UNC_TRUE]);
    out_word_nxt.uncorrected_false = FIELD_BITS'(cnt_nxt[CNT_UNC_FALSE]);
    out_word_nxt.corrected_total   = FIELD_BITS'(cnt_nxt[CNT_CORR_TOT]);
    out_word_nxt.uncorrected_total = FIELD_BITS'(cnt_nxt[CNT_UNC_TOT]);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_r <= in_word;
    end
  end

  // Running counts, cleared after a last column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COUNTS; k++) cnt_r[k] <= '0;
    end else if (s1_adv) begin
      for (int k = 0; k < NUM_COUNTS; k++) begin
        cnt_r[k] <= s1_r.last_column ? '0 : cnt_nxt[k];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_r.last_column) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_r.last_column) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    cnt_zero = 1'b1;
    for (int k = 0; k < NUM_COUNTS; k++) begin
      if (cnt_r[k] != '0) cnt_zero = 1'b0;
    end
  end

  // A finished last column leaves all counts at zero.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.last_column) |=> cnt_zero)
    else $error("counts not cleared after last column");

  // A finished last column always produces a held result.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.last_column) |=> out_valid_r)
    else $error("last column produced no result");

  // Input stalls only behind a last column blocked by a full result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_last && out_valid_r && !out_ready))
    else $error("input stalled without cause");

  // A read byte is never both corrected and uncorrected.
  a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $onehot0({inc[CNT_CORR_TOT], inc[CNT_UNC_TOT]}))
    else $error("read byte in both classes");

endmodule
